/* design/assert_macros.svh */
// Assertion macros used by the binomial coefficient unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define BC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define BC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/bc_pkg.sv */
package bc_pkg;

  localparam int STATUS_W = 2;
  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_INVALID  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

  localparam logic [63:0] COEF_BOUND = 64'd18400000000000000000;

  // The running value passes the bound before the step index reaches 35.
  localparam int I_W = 6;

  localparam int COUNT_W   = 4;
  localparam int MUL_STEPS = 4;
  localparam int DIV_STEPS = 8;
  localparam logic [COUNT_W-1:0] ACC_LAST  = COUNT_W'(MUL_STEPS);
  localparam logic [COUNT_W-1:0] DIV_FIRST = COUNT_W'(MUL_STEPS + 1);
  localparam logic [COUNT_W-1:0] LAST_STEP = COUNT_W'(MUL_STEPS + DIV_STEPS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_ORDER,
    S_LAUNCH,
    S_WAIT,
    S_TEST,
    S_DONE
  } state_t;

  typedef struct packed {
    logic start;
  } mdu_cmd_t;

  typedef struct packed {
    logic done;
    logic wide;
  } mdu_rsp_t;

  typedef struct packed {
    logic                ready;
    logic                res_valid;
    logic [STATUS_W-1:0] status;
  } seq_stat_t;

  // Eight restoring division steps: returns the new remainder above the quotient byte.
  function automatic logic [I_W+7:0] div_byte(input logic [I_W-1:0] rem_in,
                                              input logic [7:0]     dividend,
                                              input logic [I_W-1:0] divisor);
    logic [I_W:0]   cur;
    logic [I_W-1:0] rem;
    logic [7:0]     q;
    rem = rem_in;
    q   = 8'h00;
    for (int b = 7; b >= 0; b--) begin
      cur = {rem, dividend[b]};
      if (cur >= {1'b0, divisor}) begin
        q[b] = 1'b1;
        cur  = cur - {1'b0, divisor};
      end
      rem = cur[I_W-1:0];
    end
    return {rem, q};
  endfunction

endpackage

/* design/binomial_coefficient_unit.sv */
// Binomial coefficient unit: answers C(n_total, r_choose) with a status code.
// A request is taken when req_valid is high and req_stall is low; req_stall is
// high from the cycle after acceptance until the result has moved into the
// output register, so one request is worked on at a time.
// The result leaves on coefficient and status under resp_valid and resp_stall.
// Status ok carries the coefficient; invalid (r above n) and overflow (a running
// value above the bound) carry a zero coefficient.
// An invalid request ends after the check, a trivial one after the ordering step,
// and otherwise the work takes k = min(r, n - r) recurrence steps, never
// more than 34 before the overflow bound stops the work.
// Without stalls a new request is taken at the edge where the previous result
// can first be taken; none is begun before that result is in the output register.
// Each step is one pass of the shared multiply and divide unit: four 32 by 32
// partial products, then eight byte-wide division steps by the step index.
// While the receiver stalls, the result is held in the output register and a
// new request may already be taken; the next result waits until it drains.
// Reset is synchronous and clears the sequencer and the output valid flag.
`include "assert_macros.svh"

module binomial_coefficient_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  logic [63:0]                 n_total,
  input  logic [31:0]                 r_choose,
  output logic                        resp_valid,
  input  logic                        resp_stall,
  output logic [63:0]                 coefficient,
  output logic [bc_pkg::STATUS_W-1:0] status
);
  import bc_pkg::*;

  seq_stat_t      stat;
  mdu_cmd_t       cmd;
  mdu_rsp_t       rsp;
  logic [63:0]    seq_coef;
  logic [63:0]    value;
  logic [63:0]    mult;
  logic [I_W-1:0] divisor;
  logic [63:0]    quot;
  logic           accept;
  logic           load;

  assign req_stall = !stat.ready;
  assign accept    = req_valid && stat.ready;
  assign load      = stat.res_valid && (!resp_valid || !resp_stall);

  bc_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .n_total     (n_total),
    .r_choose    (r_choose),
    .taken       (load),
    .stat        (stat),
    .coefficient (seq_coef),
    .cmd         (cmd),
    .value       (value),
    .mult        (mult),
    .divisor     (divisor),
    .rsp         (rsp),
    .quot        (quot)
  );

  bc_mdu u_mdu (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .value   (value),
    .mult    (mult),
    .divisor (divisor),
    .rsp     (rsp),
    .quot    (quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      resp_valid <= 1'b0;
    end else if (load) begin
      resp_valid <= 1'b1;
    end else if (!resp_stall) begin
      resp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      coefficient <= seq_coef;
      status      <= stat.status;
    end
  end

  `BC_ASSERT_ALWAYS(a_reset_clears, rst |=> !resp_valid && !req_stall, "reset not cleared")
  `BC_ASSERT(a_one_at_a_time, req_valid && !req_stall |=> req_stall, "request taken while busy")
  `BC_ASSERT(a_error_zero, resp_valid && status != STATUS_OK |-> coefficient == '0,
             "error result with nonzero coefficient")
  `BC_ASSERT(a_within_bound, resp_valid && status == STATUS_OK |-> coefficient <= COEF_BOUND,
             "coefficient above bound")

endmodule

/* design/bc_mdu.sv */
module bc_mdu (
  input  logic                  clk,
  input  logic                  rst,
  input  bc_pkg::mdu_cmd_t      cmd,
  input  logic [63:0]           value,
  input  logic [63:0]           mult,
  input  logic [bc_pkg::I_W-1:0] divisor,
  output bc_pkg::mdu_rsp_t      rsp,
  output logic [63:0]           quot
);
  import bc_pkg::*;

  logic               busy;
  logic               done;
  logic [COUNT_W-1:0] step;
  logic [63:0]        pp;
  logic [1:0]         pp_pos;
  logic [127:0]       acc;
  logic [I_W-1:0]     rem;
  logic               wide;

  logic [31:0]        a_half;
  logic [31:0]        b_half;
  logic [127:0]       addend;
  logic               is_mul;
  logic               is_acc;
  logic               is_div;
  logic [I_W-1:0]     rem_in;
  logic               wide_now;
  logic [I_W+7:0]     div_out;

  always_comb begin
    a_half   = step[1] ? value[63:32] : value[31:0];
    b_half   = step[0] ? mult[63:32] : mult[31:0];
    is_mul   = step < COUNT_W'(MUL_STEPS);
    is_acc   = (step != '0) && (step <= ACC_LAST);
    is_div   = step >= DIV_FIRST;
    rem_in   = (step == DIV_FIRST) ? acc[64 +: I_W] : rem;
    wide_now = (step == DIV_FIRST) && (acc[127:64] >= {{(64-I_W){1'b0}}, divisor});
    div_out  = div_byte(rem_in, acc[63:56], divisor);
  end

  always_comb begin
    unique case (pp_pos)
      2'd0:    addend = {64'd0, pp};
      2'd1:    addend = {32'd0, pp, 32'd0};
      2'd2:    addend = {pp, 64'd0};
      default: addend = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        if (wide_now || step == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step + COUNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      acc  <= '0;
      wide <= 1'b0;
    end else if (busy) begin
      if (is_mul) begin
        pp     <= a_half * b_half;
        pp_pos <= {1'b0, step[0]} + {1'b0, step[1]};
      end
      if (is_acc) begin
        acc <= acc + addend;
      end
      if (is_div) begin
        rem        <= div_out[I_W+7:8];
        quot       <= {quot[55:0], div_out[7:0]};
        acc[63:0]  <= {acc[55:0], 8'h00};
        wide       <= wide_now;
      end
    end
  end

  assign rsp.done = done;
  assign rsp.wide = wide;

endmodule

/* design/bc_seq.sv */
module bc_seq (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  logic [63:0]            n_total,
  input  logic [31:0]            r_choose,
  input  logic                   taken,
  output bc_pkg::seq_stat_t      stat,
  output logic [63:0]            coefficient,
  output bc_pkg::mdu_cmd_t       cmd,
  output logic [63:0]            value,
  output logic [63:0]            mult,
  output logic [bc_pkg::I_W-1:0] divisor,
  input  bc_pkg::mdu_rsp_t       rsp,
  input  logic [63:0]            quot
);
  import bc_pkg::*;

  state_t              state;
  state_t              state_next;
  logic [63:0]         n;
  logic [31:0]         r;
  logic [63:0]         diff;
  logic [31:0]         rr;
  logic [I_W-1:0]      i;
  logic [STATUS_W-1:0] status;

  logic                r_gt;
  logic                diff_lt;
  logic [31:0]         rr_next;
  logic [63:0]         top_next;
  logic                overflow;
  logic                i_last;

  always_comb begin
    r_gt     = {32'd0, r} > n;
    diff_lt  = diff < {32'd0, r};
    rr_next  = diff_lt ? diff[31:0] : r;
    top_next = diff_lt ? {32'd0, r} : diff;
    overflow = rsp.wide || (quot > COEF_BOUND);
    i_last   = {{(32-I_W){1'b0}}, i} == rr;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (accept) state_next = S_CHECK;
      S_CHECK:  state_next = r_gt ? S_DONE : S_ORDER;
      S_ORDER:  state_next = (rr_next == 32'd0) ? S_DONE : S_LAUNCH;
      S_LAUNCH: state_next = S_WAIT;
      S_WAIT:   if (rsp.done) state_next = S_TEST;
      S_TEST:   state_next = (overflow || i_last) ? S_DONE : S_LAUNCH;
      S_DONE:   if (taken) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    stat.ready     = state == S_IDLE;
    stat.res_valid = state == S_DONE;
    stat.status    = status;
    cmd.start      = state == S_LAUNCH;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          n <= n_total;
          r <= r_choose;
        end
      end
      S_CHECK: begin
        diff <= n - {32'd0, r};
        if (r_gt) begin
          status <= STATUS_INVALID;
          value  <= '0;
        end
      end
      S_ORDER: begin
        rr     <= rr_next;
        mult   <= top_next + 64'd1;
        i      <= I_W'(1);
        value  <= 64'd1;
        status <= STATUS_OK;
      end
      S_TEST: begin
        if (overflow) begin
          status <= STATUS_OVERFLOW;
          value  <= '0;
        end else begin
          value <= quot;
          if (!i_last) begin
            i    <= i + I_W'(1);
            mult <= mult + 64'd1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign coefficient = value;
  assign divisor     = i;

endmodule
